>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that a condition is true in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/crcsig_pkg.sv
`default_nettype none
package crcsig_pkg;

	localparam int TableDepth = 1024;
	localparam int CrcWindow = 32;
	localparam int HeadBytes = 64;
	localparam int CheckMax = 16;

	typedef enum logic [1:0] {
		OP_WRITE_ENTRY = 2'd0,
		OP_WRITE_VERIFY = 2'd1,
		OP_SCAN = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		OUT_TOO_SHORT = 3'd0,
		OUT_ZERO_CRC = 3'd1,
		OUT_NO_HIT = 3'd2,
		OUT_VERIFY_FAIL = 3'd3,
		OUT_MATCHED = 3'd4
	} outcome_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_BACK_RD,
		ST_BACK_CMP,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_VER_RD,
		ST_VER_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [9:0] sig_index;
		logic [15:0] sig_crc;
		logic [15:0] sig_handle;
		logic sig_deleted;
		logic [4:0] verify_len;
		logic [3:0] verify_pos;
		logic [7:0] verify_value;
		logic [7:0] data_byte;
		logic last_byte;
	} in_word_t;

	typedef struct packed {
		logic found;
		logic [15:0] virus_handle;
		logic [2:0] outcome;
		logic [15:0] computed_crc;
	} out_word_t;

	function automatic logic [15:0] crc_step(input logic [15:0] w, input logic [7:0] b);
		logic [15:0] x;
		begin
			x = {w[7:0], w[15:8]} ^ {{8{b[7]}}, b};
			x = x ^ {12'd0, x[7:4]};
			x = x ^ {x[3:0], 12'd0} ^ {3'd0, x[7:0], 5'd0};
			return x;
		end
	endfunction

endpackage
`default_nettype wire

>>> src/crc16_signature_table_matcher_top.sv
`default_nettype none
// Signature matcher with a CRC-16 keyed table.
// The input channel (in_valid, in_ready, in_data) carries one word per item.
// Opcode 0 writes a table entry and opcode 1 writes one verify byte. Opcode 2
// streams a buffer byte, one per cycle while in_ready is high, into the head
// store and the running CRC. A scan word with last_byte set starts the lookup:
// a binary search over the entry memory, a backward walk to the first equal
// key, a forward walk over entries, and a byte-by-byte verify. Each memory has
// a single read port, so every probe, walk step and verify byte takes a read
// state and a compare state. During the lookup in_ready is low.
// One result word appears on out_valid/out_data per final byte and is held
// until out_ready; the block accepts nothing while the result waits.
// Write signature_count through cfg_we and cfg_data only while idle; the
// block does not enforce this. Reset clears the controller, the CRC and the
// byte count; table contents stay undefined until written.
module crc16_signature_table_matcher_top import crcsig_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepth,
	parameter int CRC_WINDOW = CrcWindow,
	parameter int HEAD_BYTES = HeadBytes,
	parameter int CHECK_MAX = CheckMax,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int HW = $clog2(HEAD_BYTES),
	localparam int CW = $clog2(HEAD_BYTES + 1),
	localparam int PW = $clog2(CHECK_MAX) > 0 ? $clog2(CHECK_MAX) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_word_t out_data,
	input wire logic cfg_we,
	input wire logic [10:0] cfg_data
);

	logic [10:0] count_q;
	logic acc, busy, clear, start;
	logic [CW-1:0] seen;
	logic [15:0] crc, rd_key, rd_handle;
	logic rd_del;
	logic [4:0] rd_len;
	logic [AW-1:0] ent_raddr, ventry;
	logic [PW-1:0] vpos;
	logic [7:0] vb_rdata, head_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	assign in_ready = !busy;
	assign acc = in_valid && in_ready;
	assign start = acc && in_data.opcode == OP_SCAN && in_data.last_byte;

	crcsig_head #(.CRC_WINDOW(CRC_WINDOW), .HEAD_BYTES(HEAD_BYTES)) u_head (
		.clk, .arst_n,
		.byte_en(acc && in_data.opcode == OP_SCAN),
		.byte_in(in_data.data_byte),
		.clear,
		.rd_addr(HW'(vpos)),
		.rd_data(head_rdata),
		.seen, .crc
	);

	crcsig_table #(.TABLE_DEPTH(TABLE_DEPTH), .CHECK_MAX(CHECK_MAX)) u_table (
		.clk,
		.ent_we(acc && in_data.opcode == OP_WRITE_ENTRY &&
			32'(in_data.sig_index) < TABLE_DEPTH),
		.ent_waddr(AW'(in_data.sig_index)),
		.ent_key(in_data.sig_crc),
		.ent_handle(in_data.sig_handle),
		.ent_del(in_data.sig_deleted),
		.ent_len(in_data.verify_len),
		.ent_raddr,
		.rd_key, .rd_handle, .rd_del, .rd_len,
		.vb_we(acc && in_data.opcode == OP_WRITE_VERIFY &&
			32'(in_data.sig_index) < TABLE_DEPTH && 32'(in_data.verify_pos) < CHECK_MAX),
		.vb_waddr({AW'(in_data.sig_index), PW'(in_data.verify_pos)}),
		.vb_wdata(in_data.verify_value),
		.vb_raddr({ventry, vpos}),
		.vb_rdata
	);

	crcsig_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .CRC_WINDOW(CRC_WINDOW),
		.HEAD_BYTES(HEAD_BYTES), .CHECK_MAX(CHECK_MAX)) u_ctrl (
		.clk, .arst_n, .start,
		.count_cfg(count_q),
		.seen, .crc,
		.ent_raddr,
		.rd_key, .rd_handle, .rd_del, .rd_len,
		.vpos, .ventry, .vb_rdata, .head_rdata,
		.busy,
		.res_valid(out_valid),
		.res_ready(out_ready),
		.res(out_data),
		.clear
	);

endmodule
`default_nettype wire

>>> src/crcsig_head.sv
`default_nettype none
`include "assert_macros.svh"
module crcsig_head import crcsig_pkg::*; #(
	parameter int CRC_WINDOW = CrcWindow,
	parameter int HEAD_BYTES = HeadBytes,
	localparam int HW = $clog2(HEAD_BYTES),
	localparam int CW = $clog2(HEAD_BYTES + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_en,
	input wire logic [7:0] byte_in,
	input wire logic clear,
	input wire logic [HW-1:0] rd_addr,
	output logic [7:0] rd_data,
	output logic [CW-1:0] seen,
	output logic [15:0] crc
);

	logic [7:0] mem [HEAD_BYTES];
	logic [CW-1:0] seen_q, seen_nx;
	logic [15:0] crc_q, crc_nx;
	logic take;

	assign take = byte_en && seen_q < CW'(HEAD_BYTES);
	assign seen_nx = take ? seen_q + 1'b1 : seen_q;
	assign crc_nx = (take && seen_q < CW'(CRC_WINDOW)) ? crc_step(crc_q, byte_in) : crc_q;

	always_ff @(posedge clk) begin
		if (take) begin
			mem[seen_q[HW-1:0]] <= byte_in;
		end
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			crc_q <= '0;
		end else if (clear) begin
			seen_q <= '0;
			crc_q <= '0;
		end else begin
			seen_q <= seen_nx;
			crc_q <= crc_nx;
		end
	end

	// The count and CRC include the word accepted in this cycle.
	assign seen = seen_nx;
	assign crc = crc_nx;

	`ASSERT_IMPL(a_seen_bound, clk, arst_n, 1'b1, seen_q <= CW'(HEAD_BYTES))
	`ASSERT_NEXT(a_clear, clk, arst_n, clear, seen_q == '0 && crc_q == '0)

endmodule
`default_nettype wire

>>> src/crcsig_table.sv
`default_nettype none
module crcsig_table import crcsig_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepth,
	parameter int CHECK_MAX = CheckMax,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int PW = $clog2(CHECK_MAX) > 0 ? $clog2(CHECK_MAX) : 1
) (
	input wire logic clk,
	input wire logic ent_we,
	input wire logic [AW-1:0] ent_waddr,
	input wire logic [15:0] ent_key,
	input wire logic [15:0] ent_handle,
	input wire logic ent_del,
	input wire logic [4:0] ent_len,
	input wire logic [AW-1:0] ent_raddr,
	output logic [15:0] rd_key,
	output logic [15:0] rd_handle,
	output logic rd_del,
	output logic [4:0] rd_len,
	input wire logic vb_we,
	input wire logic [AW+PW-1:0] vb_waddr,
	input wire logic [7:0] vb_wdata,
	input wire logic [AW+PW-1:0] vb_raddr,
	output logic [7:0] vb_rdata
);

	logic [37:0] ent_mem [TABLE_DEPTH];
	logic [7:0] vb_mem [TABLE_DEPTH * (1 << PW)];
	logic [37:0] ent_rd;

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= {ent_key, ent_handle, ent_del, ent_len};
		end
		ent_rd <= ent_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (vb_we) begin
			vb_mem[vb_waddr] <= vb_wdata;
		end
		vb_rdata <= vb_mem[vb_raddr];
	end

	assign {rd_key, rd_handle, rd_del, rd_len} = ent_rd;

endmodule
`default_nettype wire

>>> src/crcsig_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module crcsig_ctrl import crcsig_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepth,
	parameter int CRC_WINDOW = CrcWindow,
	parameter int HEAD_BYTES = HeadBytes,
	parameter int CHECK_MAX = CheckMax,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int NW = AW + 2,
	localparam int HW = $clog2(HEAD_BYTES),
	localparam int CW = $clog2(HEAD_BYTES + 1),
	localparam int PW = $clog2(CHECK_MAX) > 0 ? $clog2(CHECK_MAX) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [10:0] count_cfg,
	input wire logic [CW-1:0] seen,
	input wire logic [15:0] crc,
	output logic [AW-1:0] ent_raddr,
	input wire logic [15:0] rd_key,
	input wire logic [15:0] rd_handle,
	input wire logic rd_del,
	input wire logic [4:0] rd_len,
	output logic [PW-1:0] vpos,
	output logic [AW-1:0] ventry,
	input wire logic [7:0] vb_rdata,
	input wire logic [7:0] head_rdata,
	output logic busy,
	output logic res_valid,
	input wire logic res_ready,
	output out_word_t res,
	output logic clear
);

	state_t state_q, state_d;
	logic signed [NW-1:0] lo_q, hi_q, k_q, lo_d, hi_d, k_d;
	logic signed [NW-1:0] cnt_q, cnt_d, mid;
	logic [4:0] vi_q, vi_d, vlen_q, vlen_d, len_q, len_d;
	logic [15:0] handle_q, handle_d;
	out_word_t res_q, res_d;
	logic [NW-1:0] cnt_clip;

	assign cnt_clip = (32'(count_cfg) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(count_cfg);
	assign mid = (lo_q + hi_q) >>> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
		k_q <= k_d;
		cnt_q <= cnt_d;
		vi_q <= vi_d;
		vlen_q <= vlen_d;
		len_q <= len_d;
		handle_q <= handle_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		lo_d = lo_q;
		hi_d = hi_q;
		k_d = k_q;
		cnt_d = cnt_q;
		vi_d = vi_q;
		vlen_d = vlen_q;
		len_d = len_q;
		handle_d = handle_q;
		res_d = res_q;
		clear = 1'b0;
		ent_raddr = k_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					clear = 1'b1;
					res_d = '0;
					cnt_d = NW'(cnt_clip);
					if (seen < CW'(CRC_WINDOW)) begin
						res_d.outcome = OUT_TOO_SHORT;
						state_d = ST_DONE;
					end else if (crc == 16'd0) begin
						res_d.outcome = OUT_ZERO_CRC;
						state_d = ST_DONE;
					end else begin
						res_d.computed_crc = crc;
						res_d.outcome = OUT_NO_HIT;
						lo_d = '0;
						hi_d = NW'(cnt_clip) - 1'b1;
						len_d = (seen > CW'(31)) ? 5'd31 : 5'(seen);
						state_d = ST_SRCH_RD;
					end
				end
			end
			ST_SRCH_RD: begin
				if (lo_q > hi_q) begin
					state_d = ST_DONE;
				end else begin
					ent_raddr = mid[AW-1:0];
					k_d = mid;
					state_d = ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				if (res_q.computed_crc < rd_key) begin
					hi_d = k_q - 1'b1;
					state_d = ST_SRCH_RD;
				end else if (res_q.computed_crc > rd_key) begin
					lo_d = k_q + 1'b1;
					state_d = ST_SRCH_RD;
				end else begin
					res_d.outcome = OUT_VERIFY_FAIL;
					state_d = ST_BACK_RD;
				end
			end
			ST_BACK_RD: begin
				if (k_q == '0) begin
					state_d = ST_WALK_RD;
				end else begin
					ent_raddr = AW'(k_q - 1'b1);
					state_d = ST_BACK_CMP;
				end
			end
			ST_BACK_CMP: begin
				if (rd_key == res_q.computed_crc) begin
					k_d = k_q - 1'b1;
					state_d = ST_BACK_RD;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				if (k_q >= cnt_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_WALK_CMP;
				end
			end
			ST_WALK_CMP: begin
				if (rd_del) begin
					k_d = k_q + 1'b1;
					state_d = ST_WALK_RD;
				end else if (rd_key != res_q.computed_crc) begin
					state_d = ST_DONE;
				end else begin
					vi_d = '0;
					vlen_d = rd_len;
					handle_d = rd_handle;
					if (rd_len == 5'd0) begin
						res_d.found = 1'b1;
						res_d.virus_handle = rd_handle;
						res_d.outcome = OUT_MATCHED;
						state_d = ST_DONE;
					end else if (rd_len > len_q || 32'(rd_len) > CHECK_MAX) begin
						k_d = k_q + 1'b1;
						state_d = ST_WALK_RD;
					end else begin
						state_d = ST_VER_RD;
					end
				end
			end
			ST_VER_RD: begin
				state_d = ST_VER_CMP;
			end
			ST_VER_CMP: begin
				if (head_rdata != 8'(vb_rdata - 8'd1)) begin
					k_d = k_q + 1'b1;
					state_d = ST_WALK_RD;
				end else if (vi_q + 1'b1 == vlen_q) begin
					res_d.found = 1'b1;
					res_d.virus_handle = handle_q;
					res_d.outcome = OUT_MATCHED;
					state_d = ST_DONE;
				end else begin
					vi_d = vi_q + 1'b1;
					state_d = ST_VER_RD;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign vpos = vi_q[PW-1:0];
	assign ventry = k_q[AW-1:0];
	assign busy = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res = res_q;

	`ASSERT_IMPL(a_found_out, clk, arst_n, res_valid,
		res_q.found == (res_q.outcome == OUT_MATCHED))
	`ASSERT_IMPL(a_short_crc, clk, arst_n,
		res_valid && res_q.outcome == OUT_TOO_SHORT, res_q.computed_crc == '0)
	`ASSERT_NEXT(a_start_leave, clk, arst_n, start && state_q == ST_IDLE, state_q != ST_IDLE)

endmodule
`default_nettype wire
